/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tempit_pkg.sv */
package tempit_pkg;

   // Operation codes of an input beat.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Decoded bus addresses. The mirror addresses one above each are ignored.
   localparam logic [15:0] ADDR_CONTROL = 16'h0800;
   localparam logic [15:0] ADDR_PRELOAD = 16'h0802;

   // Bit of the control byte that enables counting.
   localparam int unsigned ENABLE_BIT = 7;

   typedef struct packed {
      logic        operation;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } req_item_type;

   typedef struct packed {
      logic irq_pulse;
      logic timer_enabled;
   } rsp_item_type;

endpackage

/* hw/rtl/tempit_core.sv */
module tempit_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  tempit_pkg::req_item_type item,
   output tempit_pkg::rsp_item_type result
);
   import tempit_pkg::*;

   logic       enable_ff,   enable_in;
   logic [7:0] preload_ff,  preload_in;
   logic [7:0] period_ff,   period_in;
   logic [7:0] seen_ff,     seen_in;
   logic [7:0] count_ff,    count_in;
   logic       pulse;
   logic [7:0] count_base;

   // Next state and result for the beat in the input register.
   always_comb begin
      enable_in  = enable_ff;
      preload_in = preload_ff;
      period_in  = period_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      pulse      = 1'b0;
      count_base = count_ff;
      unique case (item.operation)
         OP_TICK: begin
            // A changed period restarts the count.
            if (seen_ff != period_ff) begin
               count_base = 8'd0;
            end
            seen_in  = period_ff;
            count_in = count_base;
            if (enable_ff) begin
               if (count_base > period_ff) begin
                  count_in = 8'd0;
                  pulse    = 1'b1;
               end else begin
                  count_in = count_base + 8'd1;
               end
            end
         end
         default: begin
            if (item.bus_address == ADDR_CONTROL) begin
               enable_in = item.write_data[ENABLE_BIT];
               // Latch a nonzero, changed preload as the new period when the write sets the enable bit.
               if (item.write_data[ENABLE_BIT] && (preload_ff != period_ff)
                   && (preload_ff != 8'd0)) begin
                  period_in = preload_ff;
               end
            end else if (item.bus_address == ADDR_PRELOAD) begin
               preload_in = item.write_data;
            end
         end
      endcase
      result.irq_pulse     = pulse;
      result.timer_enabled = enable_in;
   end

   // Timer state advances once per beat that moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         preload_ff <= 8'd0;
         period_ff  <= 8'd0;
         seen_ff    <= 8'd0;
         count_ff   <= 8'd0;
      end else if (fire) begin
         enable_ff  <= enable_in;
         preload_ff <= preload_in;
         period_ff  <= period_in;
         seen_ff    <= seen_in;
         count_ff   <= count_in;
      end
   end

endmodule

/* hw/rtl/tempo_interrupt_timer_top.sv */
`include "assert_macros.svh"

// Periodic interrupt timer driven by a stream of bus writes and ticks. Each
// request beat is registered, processed from the input register against the
// timer state, and its one response beat (interrupt pulse and enable flag)
// is held in an output register; one beat per cycle is sustained while
// the response side does not stall, limited only by the single state
// update between the input and output registers. A response stall holds the
// output register and a full input register; requests stall only when both are full.
module tempo_interrupt_timer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_irq_pulse,
   output logic        rsp_timer_enabled
);
   import tempit_pkg::*;

   logic         in_valid_ff,  in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         fire;

   // The pipeline moves when the output register is empty or being taken.
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   tempit_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   // Valid bits of the input and output registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on their own handshakes.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.operation   <= req_operation;
         in_item_ff.bus_address <= req_bus_address;
         in_item_ff.write_data  <= req_write_data;
      end
      if (fire) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_irq_pulse     = rsp_item_ff.irq_pulse;
   assign rsp_timer_enabled = rsp_item_ff.timer_enabled;

   `ASSERT_IMPL(a_pulse_needs_enable, clock, reset, rsp_valid_ff && rsp_item_ff.irq_pulse, rsp_item_ff.timer_enabled, "interrupt pulse while timer disabled")
   `ASSERT_NEXT(a_accept_fills_input, clock, reset, req_valid && !req_stall, in_valid_ff, "accepted request beat not held in input register")
   `ASSERT_IMPL(a_full_pipe_stalls, clock, reset, in_valid_ff && rsp_valid_ff && rsp_stall, req_stall, "request taken while both registers are full")

endmodule
